FILE: src/lmis_pkg.sv
// lmis_pkg: types and constants shared by the last-match index search core
// item structs for the input and result channels, register indexes, scan states
// no dependencies

package lmis_pkg;

  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned TABLE_SIZE_W = 11;
  localparam int unsigned POSITION_W   = 10;
  localparam int unsigned IN_KEY_W     = 32;
  localparam int unsigned RESULT_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_NOMATCH_VAL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_SIZE  = 8'd1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic signed [RESULT_W-1:0] NOMATCH_VAL_RESET = -32'sd1;

  typedef struct packed {
    logic                  kind;
    logic [POSITION_W-1:0] entry_position;
    logic [IN_KEY_W-1:0]   key_value;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [RESULT_W-1:0] result_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } scan_state_e;

endpackage

FILE: src/lmis_key_ram.sv
// lmis_key_ram: key table storage, one write port and one read port
// synchronous read, data registered in the cycle after the request; contents undefined until written
// no dependencies

module lmis_key_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lmis_scan_ctrl.sv
// lmis_scan_ctrl: input handshake, table writes and the sequential match scan
// walks the key table one read per cycle and keeps the last matching position
// depends on lmis_pkg

module lmis_scan_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned AW          = 10,
  parameter int unsigned CW          = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  lmis_pkg::in_item_t                    in_data_i,
  input  logic [CW-1:0]                         limit_i,
  input  logic signed [lmis_pkg::RESULT_W-1:0]  nomatch_val_i,
  output logic                                  ram_we_o,
  output logic [AW-1:0]                         ram_waddr_o,
  output logic [KEY_WIDTH-1:0]                  ram_wdata_o,
  output logic                                  ram_re_o,
  output logic [AW-1:0]                         ram_raddr_o,
  input  logic [KEY_WIDTH-1:0]                  ram_rdata_i,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output lmis_pkg::out_item_t                   res_o
);

  localparam int unsigned SW = (CW > lmis_pkg::TABLE_SIZE_W) ? CW : lmis_pkg::TABLE_SIZE_W;

  lmis_pkg::scan_state_e state_q, state_d;

  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        limit_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 cmp_vld_q;
  logic [AW-1:0]        cmp_idx_q;
  logic                 hit_q;
  logic [AW-1:0]        best_q;

  logic in_xfer;
  logic query_xfer;
  logic pos_ok;
  logic match;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign query_xfer = in_xfer && (in_data_i.kind == lmis_pkg::KIND_QUERY);
  assign pos_ok     = SW'(in_data_i.entry_position) < SW'(TABLE_DEPTH);
  assign match      = cmp_vld_q && (ram_rdata_i == key_q);

  assign ram_we_o    = in_xfer && (in_data_i.kind == lmis_pkg::KIND_LOAD) && pos_ok;
  assign ram_waddr_o = AW'(in_data_i.entry_position);
  assign ram_wdata_o = KEY_WIDTH'(in_data_i.key_value);
  assign ram_raddr_o = cnt_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    ram_re_o    = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      lmis_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_data_i.kind == lmis_pkg::KIND_QUERY)) begin
          state_d = (limit_i == '0) ? lmis_pkg::ST_FINISH : lmis_pkg::ST_SCAN;
        end
      end
      lmis_pkg::ST_SCAN: begin
        ram_re_o = 1'b1;
        if ((cnt_q + CW'(1)) == limit_q) begin
          state_d = lmis_pkg::ST_DRAIN;
        end
      end
      lmis_pkg::ST_DRAIN: begin
        state_d = lmis_pkg::ST_FINISH;
      end
      lmis_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = lmis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lmis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lmis_pkg::ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= ram_re_o;
      if (query_xfer) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (ram_re_o) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      key_q   <= KEY_WIDTH'(in_data_i.key_value);
      limit_q <= limit_i;
    end
    cmp_idx_q <= cnt_q[AW-1:0];
    if (match) begin
      best_q <= cmp_idx_q;
    end
  end

  assign res_o.found        = hit_q;
  assign res_o.result_index = hit_q ? lmis_pkg::RESULT_W'(best_q) : nomatch_val_i;

`ifndef SYNTHESIS
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> (cnt_q < limit_q))
    else $error("table read beyond the active size");

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("table write during a scan");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_xfer && (limit_i != '0)) |=> ram_re_o)
    else $error("query with a nonempty table did not start reading");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && hit_q) |-> (CW'(best_q) < limit_q))
    else $error("reported position outside the active size");
`endif

endmodule

FILE: src/last_match_index_search_core.sv
// last_match_index_search_core: top level of the last-match index search
// holds the configuration registers and the result register
// depends on lmis_pkg, lmis_key_ram, lmis_scan_ctrl
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i): a load transfer writes
//   key_value at entry_position; a query transfer searches for key_value.
//   out channel (out_valid_o / out_ready_i / out_data_o): one result per query,
//   found and the highest matching position below table_size, or
//   the no-match value when nothing matched. loads give no result.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): index 0
//   is the no-match value, index 1 is table_size; always ready, write only when idle.
// timing:
//   a load is written as it is accepted. a query reads one table entry per cycle
//   through the single read port of the key memory and passes through the scan,
//   drain and finish states before the next item is taken; an empty table goes
//   straight to finish.
//   the result sits in an output register; a stalled receiver holds it there
//   while loads keep being accepted, and a later query waits only for that
//   register to drain before it delivers.
// reset:
//   control and configuration clear (no-match value -1, table_size 0); the key
//   table is not cleared and must be loaded before it is searched.

module last_match_index_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lmis_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lmis_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lmis_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [lmis_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = (CW > lmis_pkg::TABLE_SIZE_W) ? CW : lmis_pkg::TABLE_SIZE_W;

  logic signed [lmis_pkg::RESULT_W-1:0] nomatch_val_q;
  logic [lmis_pkg::TABLE_SIZE_W-1:0]    table_size_q;
  logic [CW-1:0]                        limit;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic                res_valid;
  logic                res_ready;
  lmis_pkg::out_item_t res;

  logic                out_valid_q;
  lmis_pkg::out_item_t out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nomatch_val_q <= lmis_pkg::NOMATCH_VAL_RESET;
      table_size_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lmis_pkg::REG_NOMATCH_VAL: nomatch_val_q <= cfg_data_i;
        lmis_pkg::REG_TABLE_SIZE:  table_size_q <= cfg_data_i[lmis_pkg::TABLE_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (SW'(table_size_q) > SW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                        : CW'(table_size_q);

  lmis_key_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH),
    .AW    (AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lmis_scan_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_scan_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .limit_i       (limit),
    .nomatch_val_i (nomatch_val_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // result register, refilled as it drains
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
